### rtl/radix2_complex_fft_defines.svh
// assertion macros for the radix-2 fft checker
// no dependencies; included by the checker file only
`ifndef RADIX2_COMPLEX_FFT_DEFINES_SVH
`define RADIX2_COMPLEX_FFT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define R2FFT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define R2FFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/r2fft_pkg.sv
// shared types, constants and the twiddle generator for the radix-2 fft
// no dependencies
package r2fft_pkg;

    localparam int ACC_BITS = 24;
    localparam int TW_BITS  = 17;

    typedef enum logic [1:0] {
        REG_DIRECTION = 2'd0,
        REG_LEN_LOG2  = 2'd1
    } reg_index_t;

    typedef enum logic [1:0] {
        SRC_COPY = 2'd0,
        SRC_BF_A = 2'd1,
        SRC_BF_B = 2'd2
    } res_src_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COPY,
        ST_COPY_TAIL,
        ST_BF_RD,
        ST_BF_MUL,
        ST_BF_SUM,
        ST_BF_WA,
        ST_BF_WB
    } state_t;

    typedef struct packed {
        logic     load_we;
        logic     res_we;
        res_src_t res_src;
        logic     bf_mul;
        logic     bf_sum;
        logic     last_stage;
        logic     fwd;
        logic     clear_flag;
        logic     frame_done;
    } cmd_t;

    // floor integer square root, elaboration only
    function automatic longint unsigned isqrt64(longint unsigned x_in);
        longint unsigned x;
        longint unsigned res;
        longint unsigned bitv;
        x    = x_in;
        res  = 0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (bitv > x)
                bitv = bitv >> 2;
        end
        for (int i = 0; i < 32; i++)
        begin
            if (bitv != 0)
            begin
                if (x >= res + bitv)
                begin
                    x   = x - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    // {cos, sin} of twiddle k, scale 2^15, elaboration only
    function automatic logic [2*TW_BITS-1:0] tw_entry(int maxlog, int k);
        longint bc [0:12];
        longint bs [0:12];
        longint c;
        longint s;
        longint nc;
        longint ns;
        longint one;
        longint unsigned pc;
        longint unsigned ps;
        longint rc;
        longint rs;
        one = 64'sd1 <<< 30;
        for (int m = 0; m <= 12; m++)
        begin
            bc[m] = 0;
            bs[m] = 0;
        end
        bc[0] = one;
        bc[1] = -one;
        for (int m = 2; m <= 12; m++)
        begin
            if (m <= maxlog)
            begin
                pc    = longint'(unsigned'((one + bc[m-1]) >>> 1));
                ps    = longint'(unsigned'((one - bc[m-1]) >>> 1));
                bc[m] = longint'(isqrt64(pc << 30));
                bs[m] = longint'(isqrt64(ps << 30));
            end
        end
        c = one;
        s = 0;
        for (int b = 0; b < 11; b++)
        begin
            if ((b + 1 < maxlog) && (((k >> b) & 1) == 1))
            begin
                nc = (c * bc[maxlog-b] - s * bs[maxlog-b] + (64'sd1 <<< 29)) >>> 30;
                ns = (c * bs[maxlog-b] + s * bc[maxlog-b] + (64'sd1 <<< 29)) >>> 30;
                c  = nc;
                s  = ns;
            end
        end
        rc = (c + 64'sd16384) >>> 15;
        rs = (s + 64'sd16384) >>> 15;
        return {rc[TW_BITS-1:0], rs[TW_BITS-1:0]};
    endfunction

endpackage

### rtl/radix2_complex_fft.sv
// top level of the radix-2 decimation-in-time fft
// depends on r2fft_pkg, r2fft_ctrl, r2fft_datapath
//
// usage
//   samples enter on sample_re/sample_im; a transaction is accepted at a clock
//   edge where start is high and busy is low
//   frames hold 2^len_log2 points; each accepted sample also releases one bin
//   of the previous frame, in natural order, so the last frame is flushed
//   with zero samples
//   a bin appears in the cycle after its sample is accepted, with bin_valid high
//   for exactly that cycle; the receiver cannot hold it off
//   while loading, a sample can be taken every cycle
//   the sample that fills a frame starts the transform and raises busy for
//   a bit-reversed copy pass and then the butterflies of every stage, one at a
//   time in the single butterfly unit: read, multiply, sum and its two
//   result-buffer writes
//   configuration: cfg_we writes cfg_data to register cfg_index (0 direction,
//   1 len_log2) with no wait; write only while idle; a length write restarts
//   loading and drops a pending frame unless a sample is accepted in that cycle
//   reset: forward direction, length 2^10 (or the maximum), no frame pending;
//   buffers are not cleared and need no clearing pass
module radix2_complex_fft #(
    parameter int MAX_LOG_POINTS = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [SAMPLE_BITS-1:0] sample_re,
    input  logic signed [SAMPLE_BITS-1:0] sample_im,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [3:0]                    cfg_data,
    output logic                          bin_valid,
    output logic signed [SAMPLE_BITS-1:0] bin_re,
    output logic signed [SAMPLE_BITS-1:0] bin_im,
    output logic [MAX_LOG_POINTS-1:0]     bin_index,
    output logic                          bin_last,
    output logic                          saturated
);
    import r2fft_pkg::*;

    localparam int TAW = (MAX_LOG_POINTS > 1) ? MAX_LOG_POINTS - 1 : 1;

    // command bundle from sequencer to datapath
    cmd_t                    cmd;
    logic [MAX_LOG_POINTS-1:0] load_waddr;
    logic [MAX_LOG_POINTS-1:0] load_raddr;
    logic [MAX_LOG_POINTS-1:0] res_waddr;
    logic [MAX_LOG_POINTS-1:0] res_raddr_a;
    logic [MAX_LOG_POINTS-1:0] res_raddr_b;
    logic [TAW-1:0]            tw_addr;

    // sequencer: load counter, copy pass, stage and butterfly counters
    r2fft_ctrl #(.MAX_LOG_POINTS(MAX_LOG_POINTS), .TAW(TAW)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .load_waddr  (load_waddr),
        .load_raddr  (load_raddr),
        .res_waddr   (res_waddr),
        .res_raddr_a (res_raddr_a),
        .res_raddr_b (res_raddr_b),
        .tw_addr     (tw_addr),
        .bin_valid   (bin_valid),
        .bin_index   (bin_index),
        .bin_last    (bin_last)
    );

    // buffers, twiddle rom, complex multiply and add/scale/saturate
    r2fft_datapath #(
        .MAX_LOG_POINTS (MAX_LOG_POINTS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .TAW            (TAW)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sample_re   (sample_re),
        .sample_im   (sample_im),
        .load_waddr  (load_waddr),
        .load_raddr  (load_raddr),
        .res_waddr   (res_waddr),
        .res_raddr_a (res_raddr_a),
        .res_raddr_b (res_raddr_b),
        .tw_addr     (tw_addr),
        .bin_re      (bin_re),
        .bin_im      (bin_im),
        .saturated   (saturated)
    );

endmodule

### rtl/r2fft_ram.sv
// generic single-write, single-read ram with registered read
// no dependencies
module r2fft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

### rtl/r2fft_twiddle_rom.sv
// twiddle rom, {cos, sin} per entry, registered read
// depends on r2fft_pkg for the generator function
module r2fft_twiddle_rom #(
    parameter int MAX_LOG_POINTS = 10,
    parameter int TAW = (MAX_LOG_POINTS > 1) ? MAX_LOG_POINTS - 1 : 1
) (
    input  logic                               clk,
    input  logic [TAW-1:0]                     addr,
    output logic [2*r2fft_pkg::TW_BITS-1:0]    q
);
    import r2fft_pkg::*;

    localparam int DEPTH = 1 << TAW;

    logic [2*TW_BITS-1:0] rom [0:DEPTH-1];

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_tab
        localparam logic [2*TW_BITS-1:0] TW = tw_entry(MAX_LOG_POINTS, k);
        assign rom[k] = TW;
    end

    always_ff @(posedge clk)
    begin
        q <= rom[addr];
    end

endmodule

### rtl/r2fft_datapath.sv
// buffers, twiddle rom and butterfly arithmetic of the radix-2 fft
// depends on r2fft_pkg, r2fft_ram, r2fft_twiddle_rom
module r2fft_datapath #(
    parameter int MAX_LOG_POINTS = 10,
    parameter int SAMPLE_BITS = 16,
    parameter int TAW = (MAX_LOG_POINTS > 1) ? MAX_LOG_POINTS - 1 : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  r2fft_pkg::cmd_t               cmd,
    input  logic signed [SAMPLE_BITS-1:0] sample_re,
    input  logic signed [SAMPLE_BITS-1:0] sample_im,
    input  logic [MAX_LOG_POINTS-1:0]     load_waddr,
    input  logic [MAX_LOG_POINTS-1:0]     load_raddr,
    input  logic [MAX_LOG_POINTS-1:0]     res_waddr,
    input  logic [MAX_LOG_POINTS-1:0]     res_raddr_a,
    input  logic [MAX_LOG_POINTS-1:0]     res_raddr_b,
    input  logic [TAW-1:0]                tw_addr,
    output logic signed [SAMPLE_BITS-1:0] bin_re,
    output logic signed [SAMPLE_BITS-1:0] bin_im,
    output logic                          saturated
);
    import r2fft_pkg::*;

    localparam int NPTS = 1 << MAX_LOG_POINTS;
    localparam int AB = ACC_BITS;
    localparam logic signed [28:0] ACC_HI = 29'((64'sd1 <<< (AB - 1)) - 1);
    localparam logic signed [28:0] ACC_LO = -ACC_HI - 29'sd1;
    localparam logic signed [AB-1:0] SMP_HI = AB'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [AB-1:0] SMP_LO = -SMP_HI - AB'(1);

    logic [2*SAMPLE_BITS-1:0] load_rd;
    logic [2*AB-1:0]          res_wdata;
    logic [2*AB-1:0]          rd_a;
    logic [2*AB-1:0]          rd_b;
    logic [2*TW_BITS-1:0]     tw_q;

    r2fft_ram #(.WIDTH(2*SAMPLE_BITS), .DEPTH(NPTS)) u_load_ram (
        .clk   (clk),
        .we    (cmd.load_we),
        .waddr (load_waddr),
        .wdata ({sample_re, sample_im}),
        .raddr (load_raddr),
        .rdata (load_rd)
    );

    // two copies of the result buffer give two read ports
    r2fft_ram #(.WIDTH(2*AB), .DEPTH(NPTS)) u_res_ram_a (
        .clk   (clk),
        .we    (cmd.res_we),
        .waddr (res_waddr),
        .wdata (res_wdata),
        .raddr (res_raddr_a),
        .rdata (rd_a)
    );

    r2fft_ram #(.WIDTH(2*AB), .DEPTH(NPTS)) u_res_ram_b (
        .clk   (clk),
        .we    (cmd.res_we),
        .waddr (res_waddr),
        .wdata (res_wdata),
        .raddr (res_raddr_b),
        .rdata (rd_b)
    );

    r2fft_twiddle_rom #(.MAX_LOG_POINTS(MAX_LOG_POINTS), .TAW(TAW)) u_rom (
        .clk  (clk),
        .addr (tw_addr),
        .q    (tw_q)
    );

    logic signed [SAMPLE_BITS-1:0] ld_re;
    logic signed [SAMPLE_BITS-1:0] ld_im;
    logic signed [AB-1:0] br;
    logic signed [AB-1:0] bi;
    logic signed [TW_BITS-1:0] tw_c;
    logic signed [TW_BITS-1:0] tw_s;
    logic signed [TW_BITS:0] c18;
    logic signed [TW_BITS:0] s18;

    logic signed [AB-1:0] a_re_reg;
    logic signed [AB-1:0] a_im_reg;
    logic signed [41:0] p_rc_reg;
    logic signed [41:0] p_is_reg;
    logic signed [41:0] p_rs_reg;
    logic signed [41:0] p_ic_reg;
    logic [2*AB-1:0] pa_reg;
    logic [2*AB-1:0] pm_reg;
    logic work_flag_reg;
    logic work_flag_next;
    logic frame_flag_reg;

    logic signed [42:0] sum_r;
    logic signed [42:0] sum_i;
    logic signed [27:0] t_re;
    logic signed [27:0] t_im;
    logic [AB:0] r_pr;
    logic [AB:0] r_pi;
    logic [AB:0] r_mr;
    logic [AB:0] r_mi;

    assign ld_re = load_rd[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign ld_im = load_rd[SAMPLE_BITS-1:0];
    assign br    = rd_b[2*AB-1:AB];
    assign bi    = rd_b[AB-1:0];
    assign tw_c  = tw_q[2*TW_BITS-1:TW_BITS];
    assign tw_s  = tw_q[TW_BITS-1:0];
    assign c18   = (TW_BITS+1)'(tw_c);
    // forward transform uses the conjugate twiddle
    assign s18   = cmd.fwd ? -((TW_BITS+1)'(tw_s)) : (TW_BITS+1)'(tw_s);

    // halve with rounding (forward only), saturate to the accumulator, and on the last stage to the sample width
    // returns {flag, value}
    function automatic logic [AB:0] finish(logic signed [28:0] v, logic fwd, logic last);
        logic signed [29:0] t;
        logic signed [28:0] u;
        logic signed [AB-1:0] r;
        logic f;
        t = 30'(v) + 30'sd1;
        u = fwd ? t[29:1] : v;
        f = 1'b0;
        if (u > ACC_HI)
        begin
            r = ACC_HI[AB-1:0];
            f = 1'b1;
        end
        else if (u < ACC_LO)
        begin
            r = ACC_LO[AB-1:0];
            f = 1'b1;
        end
        else
        begin
            r = u[AB-1:0];
        end
        if (last)
        begin
            if (r > SMP_HI)
            begin
                r = SMP_HI;
                f = 1'b1;
            end
            else if (r < SMP_LO)
            begin
                r = SMP_LO;
                f = 1'b1;
            end
        end
        return {f, r};
    endfunction

    always_comb
    begin
        sum_r = 43'(p_rc_reg) - 43'(p_is_reg) + 43'sd16384;
        sum_i = 43'(p_rs_reg) + 43'(p_ic_reg) + 43'sd16384;
        t_re  = sum_r[42:15];
        t_im  = sum_i[42:15];
        r_pr  = finish(29'(a_re_reg) + 29'(t_re), cmd.fwd, cmd.last_stage);
        r_pi  = finish(29'(a_im_reg) + 29'(t_im), cmd.fwd, cmd.last_stage);
        r_mr  = finish(29'(a_re_reg) - 29'(t_re), cmd.fwd, cmd.last_stage);
        r_mi  = finish(29'(a_im_reg) - 29'(t_im), cmd.fwd, cmd.last_stage);
        work_flag_next = work_flag_reg;
        if (cmd.clear_flag)
            work_flag_next = 1'b0;
        else if (cmd.bf_sum)
            work_flag_next = work_flag_reg | r_pr[AB] | r_pi[AB] | r_mr[AB] | r_mi[AB];
    end

    always_comb
    begin
        case (cmd.res_src)
            SRC_COPY: res_wdata = {AB'(ld_re), AB'(ld_im)};
            SRC_BF_A: res_wdata = pa_reg;
            SRC_BF_B: res_wdata = pm_reg;
            default:  res_wdata = pa_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.bf_mul)
        begin
            a_re_reg <= rd_a[2*AB-1:AB];
            a_im_reg <= rd_a[AB-1:0];
            p_rc_reg <= br * c18;
            p_is_reg <= bi * s18;
            p_rs_reg <= br * s18;
            p_ic_reg <= bi * c18;
        end
        if (cmd.bf_sum)
        begin
            pa_reg <= {r_pr[AB-1:0], r_pi[AB-1:0]};
            pm_reg <= {r_mr[AB-1:0], r_mi[AB-1:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_flag_reg  <= 1'b0;
            frame_flag_reg <= 1'b0;
        end
        else
        begin
            work_flag_reg <= work_flag_next;
            if (cmd.frame_done)
                frame_flag_reg <= work_flag_reg;
        end
    end

    assign bin_re    = rd_a[AB+SAMPLE_BITS-1:AB];
    assign bin_im    = rd_a[SAMPLE_BITS-1:0];
    assign saturated = frame_flag_reg;

endmodule

### rtl/r2fft_ctrl.sv
// sequencer of the radix-2 fft: load count, copy pass, butterfly schedule, output marks
// depends on r2fft_pkg
module r2fft_ctrl #(
    parameter int MAX_LOG_POINTS = 10,
    parameter int TAW = (MAX_LOG_POINTS > 1) ? MAX_LOG_POINTS - 1 : 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [3:0]                cfg_data,
    output r2fft_pkg::cmd_t           cmd,
    output logic [MAX_LOG_POINTS-1:0] load_waddr,
    output logic [MAX_LOG_POINTS-1:0] load_raddr,
    output logic [MAX_LOG_POINTS-1:0] res_waddr,
    output logic [MAX_LOG_POINTS-1:0] res_raddr_a,
    output logic [MAX_LOG_POINTS-1:0] res_raddr_b,
    output logic [TAW-1:0]            tw_addr,
    output logic                      bin_valid,
    output logic [MAX_LOG_POINTS-1:0] bin_index,
    output logic                      bin_last
);
    import r2fft_pkg::*;

    localparam int AW = MAX_LOG_POINTS;
    localparam int LW = $clog2(MAX_LOG_POINTS + 1);
    localparam logic [LW-1:0] LEN_MAX = LW'(AW);
    localparam logic [LW-1:0] LEN_RST = LW'((AW < 10) ? AW : 10);

    state_t state_reg, state_next;
    logic          dir_reg, dir_next;
    logic          fwd_reg, fwd_next;
    logic [LW-1:0] len_reg, len_next;
    logic [AW-1:0] load_count_reg, load_count_next;
    logic          frame_ready_reg, frame_ready_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] copy_idx_reg, copy_idx_next;
    logic [LW-1:0] stage_reg, stage_next;
    logic [AW-1:0] bf_reg, bf_next;
    logic          bin_valid_reg, bin_valid_next;
    logic [AW-1:0] bin_index_reg, bin_index_next;
    logic          bin_last_reg, bin_last_next;

    logic          accept;
    logic [AW-1:0] nmask;
    logic [AW-1:0] hmask;
    logic [LW-1:0] stage_m1;
    logic [AW-1:0] low;
    logic [AW-1:0] i1;
    logic [AW-1:0] i2;
    logic [AW-1:0] ti_full;
    logic [AW-1:0] rev_idx;
    logic [4:0]    len_in;

    function automatic logic [AW-1:0] bit_rev(logic [AW-1:0] x);
        logic [AW-1:0] r;
        for (int b = 0; b < AW; b++)
            r[b] = x[AW-1-b];
        return r;
    endfunction

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign nmask    = {AW{1'b1}} >> (LEN_MAX - len_reg);
    assign hmask    = nmask >> 1;
    assign stage_m1 = stage_reg - LW'(1);
    assign low      = bf_reg & ~({AW{1'b1}} << stage_m1);
    assign i1       = ((bf_reg >> stage_m1) << stage_reg) | low;
    assign i2       = i1 | (AW'(1) << stage_m1);
    assign ti_full  = low << (LEN_MAX - stage_reg);
    assign rev_idx  = bit_rev(copy_idx_reg) >> (LEN_MAX - len_reg);
    assign len_in   = {1'b0, cfg_data};

    assign load_waddr  = load_count_reg;
    assign load_raddr  = cnt_reg;
    assign res_raddr_a = busy ? i1 : load_count_reg;
    assign res_raddr_b = i2;
    assign tw_addr     = ti_full[TAW-1:0];
    assign bin_valid   = bin_valid_reg;
    assign bin_index   = bin_index_reg;
    assign bin_last    = bin_last_reg;

    always_comb
    begin
        state_next       = state_reg;
        dir_next         = dir_reg;
        fwd_next         = fwd_reg;
        len_next         = len_reg;
        load_count_next  = load_count_reg;
        frame_ready_next = frame_ready_reg;
        cnt_next         = cnt_reg;
        copy_idx_next    = copy_idx_reg;
        stage_next       = stage_reg;
        bf_next          = bf_reg;
        bin_valid_next   = 1'b0;
        bin_index_next   = bin_index_reg;
        bin_last_next    = bin_last_reg;
        cmd              = '0;
        cmd.res_src      = SRC_COPY;
        cmd.fwd          = fwd_reg;
        cmd.last_stage   = (stage_reg == len_reg);
        res_waddr        = i1;

        if (cfg_we && cfg_index == REG_DIRECTION)
            dir_next = cfg_data[0];
        if (cfg_we && cfg_index == REG_LEN_LOG2)
        begin
            if (len_in < 5'd1)
                len_next = LW'(1);
            else if (len_in > 5'(AW))
                len_next = LEN_MAX;
            else
                len_next = len_in[LW-1:0];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_we    = 1'b1;
                    bin_valid_next = frame_ready_reg;
                    bin_index_next = load_count_reg;
                    bin_last_next  = (load_count_reg == nmask);
                    if (load_count_reg == nmask)
                    begin
                        // frame full: latch direction and start the transform
                        load_count_next  = '0;
                        frame_ready_next = 1'b0;
                        fwd_next         = dir_reg;
                        cnt_next         = '0;
                        state_next       = ST_COPY;
                    end
                    else
                    begin
                        load_count_next = load_count_reg + AW'(1);
                    end
                end
                else if (cfg_we && cfg_index == REG_LEN_LOG2)
                begin
                    load_count_next  = '0;
                    frame_ready_next = 1'b0;
                end
            end
            ST_COPY:
            begin
                // write comes in the cycle after the read
                cmd.clear_flag = 1'b1;
                cmd.res_we     = (cnt_reg != '0);
                res_waddr      = rev_idx;
                copy_idx_next  = cnt_reg;
                cnt_next       = cnt_reg + AW'(1);
                if (cnt_reg == nmask)
                    state_next = ST_COPY_TAIL;
            end
            ST_COPY_TAIL:
            begin
                cmd.res_we = 1'b1;
                res_waddr  = rev_idx;
                stage_next = LW'(1);
                bf_next    = '0;
                state_next = ST_BF_RD;
            end
            ST_BF_RD:
            begin
                state_next = ST_BF_MUL;
            end
            ST_BF_MUL:
            begin
                cmd.bf_mul = 1'b1;
                state_next = ST_BF_SUM;
            end
            ST_BF_SUM:
            begin
                cmd.bf_sum = 1'b1;
                state_next = ST_BF_WA;
            end
            ST_BF_WA:
            begin
                cmd.res_we  = 1'b1;
                cmd.res_src = SRC_BF_A;
                res_waddr   = i1;
                state_next  = ST_BF_WB;
            end
            ST_BF_WB:
            begin
                cmd.res_we  = 1'b1;
                cmd.res_src = SRC_BF_B;
                res_waddr   = i2;
                state_next  = ST_BF_RD;
                if (bf_reg == hmask)
                begin
                    bf_next = '0;
                    if (stage_reg == len_reg)
                    begin
                        cmd.frame_done   = 1'b1;
                        frame_ready_next = 1'b1;
                        state_next       = ST_IDLE;
                    end
                    else
                    begin
                        stage_next = stage_reg + LW'(1);
                    end
                end
                else
                begin
                    bf_next = bf_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            dir_reg         <= 1'b1;
            fwd_reg         <= 1'b1;
            len_reg         <= LEN_RST;
            load_count_reg  <= '0;
            frame_ready_reg <= 1'b0;
            cnt_reg         <= '0;
            stage_reg       <= LW'(1);
            bf_reg          <= '0;
            bin_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            dir_reg         <= dir_next;
            fwd_reg         <= fwd_next;
            len_reg         <= len_next;
            load_count_reg  <= load_count_next;
            frame_ready_reg <= frame_ready_next;
            cnt_reg         <= cnt_next;
            stage_reg       <= stage_next;
            bf_reg          <= bf_next;
            bin_valid_reg   <= bin_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        copy_idx_reg  <= copy_idx_next;
        bin_index_reg <= bin_index_next;
        bin_last_reg  <= bin_last_next;
    end

endmodule

### rtl/r2fft_checker.sv
// port-level checks on the radix-2 fft, bound to the top level
// depends on radix2_complex_fft_defines.svh
`include "radix2_complex_fft_defines.svh"

module r2fft_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic bin_valid,
    input logic bin_last
);

    // a bin only follows an accepted transaction
    `R2FFT_ASSERT_SAME(a_bin_after_accept, clk, rst_n, bin_valid, $past(start && !busy), "bin without accepted sample")

    // the last bin is released by the sample that fills the next frame, so busy is high with it
    `R2FFT_ASSERT_SAME(a_last_starts_fft, clk, rst_n, bin_valid && bin_last, busy, "last bin without transform")

    // the transform only starts on an accepted transaction
    `R2FFT_ASSERT_SAME(a_busy_after_start, clk, rst_n, $rose(busy), $past(start), "busy without start")

endmodule

bind radix2_complex_fft r2fft_checker u_r2fft_checker (.*);
